/* sv/flash_record_append_log_assert.svh */
// Assertion macros for the flash record append log.
// Included by the modules that check their own logic; no other dependencies.
`ifndef FLASH_RECORD_APPEND_LOG_ASSERT_SVH
`define FLASH_RECORD_APPEND_LOG_ASSERT_SVH
`ifndef SYNTH
// prop must hold at every edge outside reset
`define FRAL_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fral: assertion failed");
// cond must never be true outside reset
`define FRAL_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("fral: forbidden condition seen");
`else
`define FRAL_ASSERT(name, clk, rst, prop)
`define FRAL_ASSERT_NEVER(name, clk, rst, cond)
`endif
`endif

/* sv/fral_pkg.sv */
// Shared constants, types and controller/datapath interface structs for the
// flash record append log. No dependencies.
package fral_pkg;

  localparam int unsigned STORE_WORDS = 1024;
  localparam int unsigned MAX_RECORD  = 64;
  localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);
  localparam int unsigned PTR_W       = $clog2(STORE_WORDS + 1);
  localparam int unsigned LEN_W       = $clog2(MAX_RECORD + 1);
  localparam int unsigned IDX_W       = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam word_t ERASED_WORD = '1;

  typedef enum logic [OP_W-1:0] {
    OP_MOUNT  = 2'd0,
    OP_APPEND = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPEND,
    ST_ERASE,
    ST_MNT_MID,
    ST_MNT_CHK,
    ST_MNT_PREV,
    ST_MNT_NEXT,
    ST_READ,
    ST_RD_TAIL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic latch;        // capture beat payload, clear erased flag
    logic wr_begin;     // first word of a record: latch its length
    logic erase_begin;  // pointers to zero, flag the erase
    logic sweep;        // write erased word at sweep counter
    logic append;       // store one record word, advance pointers
    logic mnt_begin;    // open search window over the whole store
    logic mnt_mid;      // read midpoint of the window
    logic mnt_nb;       // read neighbor of the midpoint
    logic mnt_hi;       // window upper bound to midpoint
    logic mnt_lo;       // window lower bound past midpoint
    logic mnt_end;      // pointers from the found boundary
    logic end_sel;      // boundary is midpoint + 1
    logic rd_begin;     // start record readout
    logic rd_issue;     // read next record word
    logic emit;         // single result beat
  } cmd_t;

  typedef struct packed {
    logic wi_zero;
    logic overflow;
    logic sweep_last;
    logic q_erased;
    logic mid_eq_lo;
    logic mid_eq_hi;
    logic mid_lt_n;
    logic mid1_lt_n;
    logic rd_last;
  } stat_t;

endpackage

/* sv/fral_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fral_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/fral_datapath.sv */
// Datapath of the flash record append log: word store, pointers, search
// window, readout pipeline and result registers. Uses fral_pkg and fral_ram.
`include "flash_record_append_log_assert.svh"

module fral_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  fral_pkg::cfg_t        cfg_wdata,
  input  fral_pkg::word_t       data,
  input  fral_pkg::cmd_t        cmd,
  output fral_pkg::stat_t       stat,
  output logic                  strobe,
  output fral_pkg::word_t       rdata,
  output logic                  last,
  output fral_pkg::ptr_t        write_position,
  output fral_pkg::addr_t       read_position,
  output logic                  erased
);

  fral_pkg::cfg_t  record_words;
  fral_pkg::len_t  eff_len;
  fral_pkg::ptr_t  write_pointer;
  fral_pkg::addr_t read_pointer;
  fral_pkg::len_t  word_index;
  fral_pkg::len_t  active_len;
  fral_pkg::len_t  word_index_inc;
  fral_pkg::addr_t sweep_cnt;
  fral_pkg::addr_t lo;
  fral_pkg::addr_t hi;
  fral_pkg::addr_t mid;
  fral_pkg::addr_t mid_calc;
  fral_pkg::word_t data_q;
  fral_pkg::len_t  rd_k;
  fral_pkg::len_t  rd_n;
  logic            rd_pend;
  logic            rd_last_q;
  logic            rd_oob_q;
  logic            rd_oob;
  logic            erased_flag;
  fral_pkg::idx_t  app_idx;
  fral_pkg::idx_t  rd_idx;
  fral_pkg::idx_t  end_val;
  logic            ram_we;
  fral_pkg::addr_t ram_waddr;
  fral_pkg::word_t ram_wdata;
  fral_pkg::addr_t ram_raddr;
  fral_pkg::word_t ram_q;
  logic            strobe_q;
  fral_pkg::word_t rdata_q;
  logic            last_q;
  logic            erased_q;

  // effective record length: at least one, at most MAX_RECORD and the store
  always_comb begin
    if (record_words == '0) begin
      eff_len = fral_pkg::len_t'(1);
    end else if (int'(record_words) > fral_pkg::MAX_RECORD) begin
      eff_len = fral_pkg::len_t'(fral_pkg::MAX_RECORD);
    end else begin
      eff_len = fral_pkg::len_t'(record_words);
    end
    if (int'(eff_len) > fral_pkg::STORE_WORDS) begin
      eff_len = fral_pkg::len_t'(fral_pkg::STORE_WORDS);
    end
  end

  assign mid_calc = fral_pkg::addr_t'(
      (fral_pkg::idx_t'(lo) + fral_pkg::idx_t'(hi)) >> 1);
  assign app_idx  = fral_pkg::idx_t'(write_pointer) + fral_pkg::idx_t'(word_index);
  assign rd_idx   = fral_pkg::idx_t'(read_pointer) + fral_pkg::idx_t'(rd_k);
  assign rd_oob   = rd_idx >= fral_pkg::idx_t'(fral_pkg::STORE_WORDS);
  assign end_val  = cmd.end_sel ? fral_pkg::idx_t'(mid) + fral_pkg::idx_t'(1)
                                : fral_pkg::idx_t'(mid);
  assign word_index_inc = word_index + fral_pkg::len_t'(1);

  always_comb begin
    stat.wi_zero    = word_index == '0;
    stat.overflow   = fral_pkg::idx_t'(write_pointer) + fral_pkg::idx_t'(eff_len) >
                      fral_pkg::idx_t'(fral_pkg::STORE_WORDS);
    stat.sweep_last = sweep_cnt == fral_pkg::addr_t'(fral_pkg::STORE_WORDS - 1);
    stat.q_erased   = ram_q == fral_pkg::ERASED_WORD;
    stat.mid_eq_lo  = mid == lo;
    stat.mid_eq_hi  = mid == hi;
    stat.mid_lt_n   = fral_pkg::idx_t'(mid) < fral_pkg::idx_t'(eff_len);
    stat.mid1_lt_n  = fral_pkg::idx_t'(mid) + fral_pkg::idx_t'(1) <
                      fral_pkg::idx_t'(eff_len);
    stat.rd_last    = rd_k == rd_n - fral_pkg::len_t'(1);
  end

  // store port muxing
  always_comb begin
    ram_we    = cmd.sweep ||
                (cmd.append && app_idx < fral_pkg::idx_t'(fral_pkg::STORE_WORDS));
    ram_waddr = cmd.sweep ? sweep_cnt : app_idx[fral_pkg::ADDR_W-1:0];
    ram_wdata = cmd.sweep ? fral_pkg::ERASED_WORD : data_q;
    if (cmd.mnt_mid) begin
      ram_raddr = mid_calc;
    end else if (cmd.mnt_nb) begin
      // midpoint erased: look below it, otherwise above it
      ram_raddr = stat.q_erased ? mid - fral_pkg::addr_t'(1)
                                : mid + fral_pkg::addr_t'(1);
    end else begin
      ram_raddr = rd_idx[fral_pkg::ADDR_W-1:0];
    end
  end

  fral_ram #(
    .WIDTH(fral_pkg::DATA_W),
    .DEPTH(fral_pkg::STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      record_words  <= fral_pkg::cfg_t'(1);
      write_pointer <= '0;
      read_pointer  <= '0;
      word_index    <= '0;
      active_len    <= '0;
      sweep_cnt     <= '0;
      rd_k          <= '0;
      rd_n          <= '0;
      rd_pend       <= 1'b0;
      erased_flag   <= 1'b0;
      strobe_q      <= 1'b0;
    end else begin
      if (cfg_we) begin
        record_words <= cfg_wdata;
      end
      if (cmd.latch) begin
        erased_flag <= 1'b0;
      end
      if (cmd.wr_begin) begin
        active_len <= eff_len;
      end
      if (cmd.erase_begin) begin
        erased_flag   <= 1'b1;
        write_pointer <= '0;
        read_pointer  <= '0;
      end
      if (cmd.sweep) begin
        sweep_cnt <= stat.sweep_last ? '0 : sweep_cnt + fral_pkg::addr_t'(1);
      end
      if (cmd.append) begin
        if (word_index_inc >= active_len) begin
          // record complete: it becomes the newest one
          read_pointer  <= write_pointer[fral_pkg::ADDR_W-1:0];
          write_pointer <= fral_pkg::ptr_t'(fral_pkg::idx_t'(write_pointer) +
                                            fral_pkg::idx_t'(active_len));
          word_index    <= '0;
          active_len    <= '0;
        end else begin
          word_index <= word_index_inc;
        end
      end
      if (cmd.mnt_begin) begin
        word_index <= '0;
        active_len <= '0;
      end
      if (cmd.mnt_end) begin
        write_pointer <= fral_pkg::ptr_t'(end_val);
        read_pointer  <= fral_pkg::addr_t'(end_val - fral_pkg::idx_t'(eff_len));
      end
      if (cmd.rd_begin) begin
        rd_k <= '0;
        rd_n <= eff_len;
      end
      if (cmd.rd_issue) begin
        rd_k <= rd_k + fral_pkg::len_t'(1);
      end
      rd_pend  <= cmd.rd_issue;
      strobe_q <= cmd.emit || rd_pend;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      data_q <= data;
    end
    if (cmd.mnt_begin) begin
      lo <= '0;
      hi <= fral_pkg::addr_t'(fral_pkg::STORE_WORDS - 1);
    end
    if (cmd.mnt_mid) begin
      mid <= mid_calc;
    end
    if (cmd.mnt_hi) begin
      hi <= mid;
    end
    if (cmd.mnt_lo) begin
      lo <= mid + fral_pkg::addr_t'(1);
    end
    rd_last_q <= stat.rd_last;
    rd_oob_q  <= rd_oob;
    rdata_q   <= rd_pend ? (rd_oob_q ? fral_pkg::ERASED_WORD : ram_q) : '0;
    last_q    <= rd_pend ? rd_last_q : 1'b1;
    erased_q  <= !rd_pend && erased_flag;
  end

  assign strobe         = strobe_q;
  assign rdata          = rdata_q;
  assign last           = last_q;
  assign erased         = erased_q;
  assign write_position = write_pointer;
  assign read_position  = read_pointer;

  `FRAL_ASSERT(a_wp_in_store, clk, rst, write_pointer <= fral_pkg::ptr_t'(fral_pkg::STORE_WORDS))
  `FRAL_ASSERT(a_wi_in_record, clk, rst, (word_index == '0) || (word_index < active_len))
  `FRAL_ASSERT_NEVER(a_beat_collide, clk, rst, rd_pend && cmd.emit)

endmodule

/* sv/fral_ctrl.sv */
// Controller of the flash record append log: sequences clearing, append,
// erase, mount search and readout. Uses fral_pkg.
`include "flash_record_append_log_assert.svh"

module fral_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [fral_pkg::OP_W-1:0] op,
  input  fral_pkg::stat_t         stat,
  output fral_pkg::cmd_t          cmd,
  output logic                    busy
);

  fral_pkg::state_t state;
  fral_pkg::state_t state_next;
  fral_pkg::op_t    cur_op;
  fral_pkg::op_t    op_in;

  assign op_in = fral_pkg::op_t'(op);
  assign busy  = state != fral_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fral_pkg::ST_CLEAR;
      cur_op <= fral_pkg::OP_NONE;
    end else begin
      state <= state_next;
      if (start && !busy) begin
        cur_op <= op_in;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fral_pkg::ST_CLEAR: begin
        if (stat.sweep_last) begin
          state_next = fral_pkg::ST_IDLE;
        end
      end
      fral_pkg::ST_IDLE: begin
        if (start) begin
          unique case (op_in)
            fral_pkg::OP_MOUNT:  state_next = fral_pkg::ST_MNT_MID;
            fral_pkg::OP_APPEND: state_next = (stat.wi_zero && stat.overflow) ?
                                              fral_pkg::ST_ERASE : fral_pkg::ST_APPEND;
            fral_pkg::OP_READ:   state_next = fral_pkg::ST_READ;
            default:             state_next = fral_pkg::ST_RESP;
          endcase
        end
      end
      fral_pkg::ST_APPEND: state_next = fral_pkg::ST_IDLE;
      fral_pkg::ST_ERASE: begin
        if (stat.sweep_last) begin
          state_next = (cur_op == fral_pkg::OP_APPEND) ? fral_pkg::ST_APPEND
                                                       : fral_pkg::ST_IDLE;
        end
      end
      fral_pkg::ST_MNT_MID: state_next = fral_pkg::ST_MNT_CHK;
      fral_pkg::ST_MNT_CHK: begin
        if (stat.q_erased) begin
          state_next = stat.mid_eq_lo ? fral_pkg::ST_ERASE : fral_pkg::ST_MNT_PREV;
        end else begin
          state_next = stat.mid_eq_hi ? fral_pkg::ST_IDLE : fral_pkg::ST_MNT_NEXT;
        end
      end
      fral_pkg::ST_MNT_PREV: begin
        if (stat.q_erased) begin
          state_next = fral_pkg::ST_MNT_MID;
        end else begin
          state_next = stat.mid_lt_n ? fral_pkg::ST_ERASE : fral_pkg::ST_IDLE;
        end
      end
      fral_pkg::ST_MNT_NEXT: begin
        if (stat.q_erased) begin
          state_next = stat.mid1_lt_n ? fral_pkg::ST_ERASE : fral_pkg::ST_IDLE;
        end else begin
          state_next = fral_pkg::ST_MNT_MID;
        end
      end
      fral_pkg::ST_READ: begin
        if (stat.rd_last) begin
          state_next = fral_pkg::ST_RD_TAIL;
        end
      end
      // last word still in the read pipeline: hold off the next item
      fral_pkg::ST_RD_TAIL: state_next = fral_pkg::ST_IDLE;
      fral_pkg::ST_RESP: state_next = fral_pkg::ST_IDLE;
      default: state_next = fral_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state)
      fral_pkg::ST_CLEAR: cmd.sweep = 1'b1;
      fral_pkg::ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (op_in)
            fral_pkg::OP_MOUNT:  cmd.mnt_begin = 1'b1;
            fral_pkg::OP_APPEND: begin
              cmd.wr_begin    = stat.wi_zero;
              cmd.erase_begin = stat.wi_zero && stat.overflow;
            end
            fral_pkg::OP_READ:   cmd.rd_begin = 1'b1;
            default:             cmd.latch = 1'b1;
          endcase
        end
      end
      fral_pkg::ST_APPEND: begin
        cmd.append = 1'b1;
        cmd.emit   = 1'b1;
      end
      fral_pkg::ST_ERASE: begin
        cmd.sweep = 1'b1;
        cmd.emit  = stat.sweep_last && (cur_op != fral_pkg::OP_APPEND);
      end
      fral_pkg::ST_MNT_MID: cmd.mnt_mid = 1'b1;
      fral_pkg::ST_MNT_CHK: begin
        if (stat.q_erased) begin
          cmd.erase_begin = stat.mid_eq_lo;
          cmd.mnt_nb      = !stat.mid_eq_lo;
        end else begin
          // last entry holds data: the store is full
          cmd.mnt_end = stat.mid_eq_hi;
          cmd.end_sel = 1'b1;
          cmd.emit    = stat.mid_eq_hi;
          cmd.mnt_nb  = !stat.mid_eq_hi;
        end
      end
      fral_pkg::ST_MNT_PREV: begin
        if (stat.q_erased) begin
          cmd.mnt_hi = 1'b1;
        end else begin
          cmd.erase_begin = stat.mid_lt_n;
          cmd.mnt_end     = !stat.mid_lt_n;
          cmd.emit        = !stat.mid_lt_n;
        end
      end
      fral_pkg::ST_MNT_NEXT: begin
        if (stat.q_erased) begin
          cmd.erase_begin = stat.mid1_lt_n;
          cmd.mnt_end     = !stat.mid1_lt_n;
          cmd.end_sel     = 1'b1;
          cmd.emit        = !stat.mid1_lt_n;
        end else begin
          cmd.mnt_lo = 1'b1;
        end
      end
      fral_pkg::ST_READ: cmd.rd_issue = 1'b1;
      fral_pkg::ST_RESP: cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end

  `FRAL_ASSERT(a_accept_goes_busy, clk, rst, (start && !busy) |=> busy)
  `FRAL_ASSERT_NEVER(a_one_writer, clk, rst, cmd.sweep && cmd.append)
  `FRAL_ASSERT(a_tail_to_idle, clk, rst, (state == fral_pkg::ST_RD_TAIL) |=> !busy)

endmodule

/* sv/flash_record_append_log.sv */
// Flash record append log, top level: wires controller and datapath.
// Uses fral_pkg, fral_ctrl and fral_datapath.
//
// Usage: drive op/data with start high; the item is taken on an edge where
// busy is low. Results come on rdata/last/write_position/read_position/
// erased, each valid for the single cycle strobe is high; the receiver
// cannot stall them, so it must take every strobed beat.
// op 1 (append one word): result comes via the APPEND state and the
// strobe register, next item can be taken in the result cycle. If the first
// word of a record won't fit, the store is erased first, one entry per cycle.
// op 2 (read newest record): n beats (n the record length) on consecutive
// cycles via READ, the store read and result registers; last marks the final
// word. The next item is taken at the edge that ends the last beat.
// op 0 (mount): binary search over the store, each step through MNT_MID,
// MNT_CHK and MNT_PREV or MNT_NEXT on the single store read port; it may erase.
// op 3: one beat, no change.
// record length is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle; the block does not enforce it. Reset: a
// clearing pass writes all 1024 store entries to all ones with busy high;
// writes to the length register are taken during that time.
module flash_record_append_log (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [fral_pkg::OP_W-1:0]   op,
  input  fral_pkg::word_t             data,
  output logic                        strobe,
  output fral_pkg::word_t             rdata,
  output logic                        last,
  output fral_pkg::ptr_t              write_position,
  output fral_pkg::addr_t             read_position,
  output logic                        erased,
  input  logic                        cfg_we,
  input  fral_pkg::cfg_t              cfg_wdata
);

  fral_pkg::cmd_t  cmd;
  fral_pkg::stat_t stat;

  fral_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (op),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  fral_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .data          (data),
    .cmd           (cmd),
    .stat          (stat),
    .strobe        (strobe),
    .rdata         (rdata),
    .last          (last),
    .write_position(write_position),
    .read_position (read_position),
    .erased        (erased)
  );

endmodule
